### hdl/nlp_pkg.sv
// Shared types, constants and helpers for the numeric literal parser.
package nlp_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int OUT_WIDTH   = 64;
    localparam int WORTH_WIDTH = 5;

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;

    localparam logic [WORTH_WIDTH-1:0] NOT_A_DIGIT = 5'd16;

    typedef logic [VALUE_WIDTH-1:0] accum_t;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_FIRST  = 2'd1,
        PH_ZERO   = 2'd2,
        PH_DIGITS = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_OCT = 2'd2,
        RX_BIN = 2'd3
    } radix_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] value;
        logic                        bad_char;
    } out_beat_t;

    function automatic logic [WORTH_WIDTH-1:0] digit_worth(input logic [7:0] c);
        logic [WORTH_WIDTH-1:0] w;
        begin
            w = NOT_A_DIGIT;
            if (c >= 8'h30 && c <= 8'h39) begin
                w = WORTH_WIDTH'(c - 8'h30);
            end else if (c >= 8'h61 && c <= 8'h66) begin
                w = WORTH_WIDTH'(c - 8'h57);
            end else if (c >= 8'h41 && c <= 8'h46) begin
                w = WORTH_WIDTH'(c - 8'h37);
            end
            return w;
        end
    endfunction

endpackage

### hdl/numeric_literal_parser.sv
// Top level of the numeric literal parser.
//
// The input channel carries one ASCII character per beat, with last marking
// the final character of a literal. On the last beat the block returns one
// result beat holding the signed 64-bit value and a bad character flag.
// A leading minus negates the value; 0x selects hex, 0b binary, a leading
// 0 octal, and anything else decimal. An illegal character forces the value
// to zero and sets the flag.
//
// Throughput is one character per cycle unless a last beat waits for the
// result register. An accepted beat is held in an input register while the
// accumulator takes its digit; a last beat's result then goes to the result
// register. The accumulator recurrence, a radix shift-add, sets this rate.
//
// Reset empties the input and result registers and returns the parser to
// the start of a literal. When the receiver stalls, the result beat holds in
// the result register; character beats keep flowing until another last beat
// arrives, which then waits in the input register and stalls the sender.
module numeric_literal_parser import nlp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic      in_vld_reg;
    in_beat_t  in_beat_reg;
    logic      m_vld_reg;
    out_beat_t m_data_reg;

    phase_t phase_reg, phase_next;
    logic   neg_reg, neg_next;
    radix_t radix_reg, radix_next;
    accum_t acc_reg, acc_next;
    logic   err_reg, err_next;

    logic      out_free;
    logic      step;
    logic      take;
    radix_t    radix_eff;
    accum_t    digit_acc;
    logic      digit_legal;
    out_beat_t result;

    assign out_free = !m_vld_reg || m_ready;
    assign step     = in_vld_reg && (!in_beat_reg.last || out_free);
    assign s_ready  = !in_vld_reg || step;
    assign m_valid  = m_vld_reg;
    assign m_data   = m_data_reg;

    assign radix_eff = (phase_reg == PH_DIGITS) ? radix_reg :
                       (phase_reg == PH_ZERO)   ? RX_OCT    : RX_DEC;

    nlp_digit_unit u_digit (
        .acc_in   (acc_reg),
        .radix    (radix_eff),
        .negative (neg_reg),
        .ch       (in_beat_reg.ch),
        .acc_out  (digit_acc),
        .legal    (digit_legal)
    );

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        err_next   = err_reg;
        take       = 1'b0;
        if (step) begin
            unique case (phase_reg) inside
                PH_START, PH_FIRST: begin
                    if (phase_reg == PH_START && in_beat_reg.ch == CH_MINUS) begin
                        neg_next   = 1'b1;
                        phase_next = PH_FIRST;
                    end else if (in_beat_reg.ch == CH_ZERO) begin
                        radix_next = RX_OCT;
                        acc_next   = '0;
                        phase_next = PH_ZERO;
                    end else begin
                        radix_next = RX_DEC;
                        phase_next = PH_DIGITS;
                        take       = 1'b1;
                    end
                end
                PH_ZERO: begin
                    phase_next = PH_DIGITS;
                    if (in_beat_reg.ch == CH_X) begin
                        radix_next = RX_HEX;
                    end else if (in_beat_reg.ch == CH_B) begin
                        radix_next = RX_BIN;
                    end else begin
                        radix_next = RX_OCT;
                        take       = 1'b1;
                    end
                end
                default: begin
                    take = 1'b1;
                end
            endcase
            if (take && !err_reg) begin
                if (digit_legal) begin
                    acc_next = digit_acc;
                end else begin
                    err_next = 1'b1;
                    acc_next = '0;
                end
            end
        end

        result.value    = OUT_WIDTH'($signed(acc_next));
        result.bad_char = err_next;

        if (step && in_beat_reg.last) begin
            phase_next = PH_START;
            neg_next   = 1'b0;
            radix_next = RX_DEC;
            acc_next   = '0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
            phase_reg  <= PH_START;
            neg_reg    <= 1'b0;
            radix_reg  <= RX_DEC;
            acc_reg    <= '0;
            err_reg    <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (step && in_beat_reg.last) begin
                m_vld_reg <= 1'b1;
            end else if (m_ready) begin
                m_vld_reg <= 1'b0;
            end
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            radix_reg <= radix_next;
            acc_reg   <= acc_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
        if (step && in_beat_reg.last) begin
            m_data_reg <= result;
        end
    end

endmodule

### hdl/nlp_digit_unit.sv
// Digit decode and accumulator update for one character in the selected radix.
module nlp_digit_unit import nlp_pkg::*; (
    input  accum_t     acc_in,
    input  radix_t     radix,
    input  logic       negative,
    input  logic [7:0] ch,
    output accum_t     acc_out,
    output logic       legal
);

    logic [WORTH_WIDTH-1:0] worth;
    accum_t                 scaled;
    accum_t                 digit;

    assign worth = digit_worth(ch);
    assign digit = VALUE_WIDTH'(worth[3:0]);

    always_comb begin
        unique case (radix)
            RX_DEC: begin
                legal  = (worth < WORTH_WIDTH'(10));
                scaled = (acc_in << 3) + (acc_in << 1);
            end
            RX_HEX: begin
                legal  = (worth < WORTH_WIDTH'(16));
                scaled = acc_in << 4;
            end
            RX_OCT: begin
                legal  = (worth < WORTH_WIDTH'(8));
                scaled = acc_in << 3;
            end
            default: begin
                legal  = (worth < WORTH_WIDTH'(2));
                scaled = acc_in << 1;
            end
        endcase
    end

    // A negative literal accumulates its value already negated.
    assign acc_out = negative ? (scaled - digit) : (scaled + digit);

endmodule

### hdl/nlp_checker.sv
// Port-level assertions for the numeric literal parser, bound to the top level.
module nlp_checker import nlp_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // A stalled result beat holds its value.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // A stalled character beat holds its value.
    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("character beat changed while stalled");

    // Reset leaves the result channel empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // An illegal character always yields a zero value.
    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_char |-> m_data.value == '0)
        else $error("bad character with nonzero value");

    // No result appears the cycle after a character is refused with no result held.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !s_ready |=> !m_valid)
        else $error("result appeared with the parser holding a character");

endmodule

bind numeric_literal_parser nlp_checker u_nlp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### test/numeric_literal_parser_tb.sv
// Self-checking testbench for the numeric literal parser, with a handshake driver and monitor.
module numeric_literal_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nlp_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int PHASE_ITEMS   = 467;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 400000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    in_beat_t  pending_chars[$];
    out_beat_t parsed_values[$];

    logic s_took        = 1'b0;
    int   s_idle_pct    = 0;
    int   m_idle_pct    = 0;
    int   phase_items   = 0;
    int   mismatch_count = 0;
    int   cycle_count   = 0;

    phase_t lit_phase = PH_START;
    logic   lit_neg   = 1'b0;
    radix_t lit_radix = RX_DEC;
    accum_t lit_accum = '0;
    logic   lit_err   = 1'b0;

    numeric_literal_parser i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    function automatic int char_worth(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return int'(c) - 'h30;
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            return int'(c) - 'h61 + 10;
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            return int'(c) - 'h41 + 10;
        end
        return 16;
    endfunction

    function automatic int radix_base(radix_t r);
        case (r)
            RX_HEX:  return 16;
            RX_OCT:  return 8;
            RX_BIN:  return 2;
            default: return 10;
        endcase
    endfunction

    function automatic void take_digit(logic [7:0] c);
        int worth;
        int base;
        if (lit_err) begin
            return;
        end
        worth = char_worth(c);
        base  = radix_base(lit_radix);
        if (worth >= base) begin
            lit_err   = 1'b1;
            lit_accum = '0;
        end else begin
            lit_accum = accum_t'(lit_accum * accum_t'(base) + accum_t'(worth));
        end
    endfunction

    function automatic void parse_char(in_beat_t b);
        out_beat_t res;
        accum_t    v;
        if (lit_phase == PH_START && b.ch == CH_MINUS) begin
            lit_neg   = 1'b1;
            lit_phase = PH_FIRST;
        end else if (lit_phase == PH_START || lit_phase == PH_FIRST) begin
            if (b.ch == CH_ZERO) begin
                lit_radix = RX_OCT;
                lit_accum = '0;
                lit_phase = PH_ZERO;
            end else begin
                lit_radix = RX_DEC;
                lit_phase = PH_DIGITS;
                take_digit(b.ch);
            end
        end else if (lit_phase == PH_ZERO) begin
            lit_phase = PH_DIGITS;
            if (b.ch == CH_X) begin
                lit_radix = RX_HEX;
            end else if (b.ch == CH_B) begin
                lit_radix = RX_BIN;
            end else begin
                lit_radix = RX_OCT;
                take_digit(b.ch);
            end
        end else begin
            take_digit(b.ch);
        end

        if (b.last) begin
            v = lit_err ? '0 : lit_accum;
            if (lit_neg) begin
                v = -v;
            end
            res.value    = $signed(v);
            res.bad_char = lit_err;
            parsed_values.push_back(res);
            lit_phase = PH_START;
            lit_neg   = 1'b0;
            lit_radix = RX_DEC;
            lit_accum = '0;
            lit_err   = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_char(logic [7:0] c, logic last);
        in_beat_t b;
        b.ch   = c;
        b.last = last;
        pending_chars.push_back(b);
        phase_items++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            queue_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic gen_literal();
        logic [7:0] text[$];
        int         nd;
        int         d;
        int         pos;
        bit         long_run;
        bit         upper;
        radix_t     rx;
        if ($urandom_range(99) < 8) begin
            nd = $urandom_range(1, 4);
            repeat (nd) text.push_back(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(3) == 0) begin
                text.push_back(CH_MINUS);
            end
            rx       = radix_t'($urandom_range(3));
            long_run = ($urandom_range(7) == 0);
            case (rx)
                RX_DEC: begin
                    nd = long_run ? $urandom_range(15, 24) : $urandom_range(1, 6);
                    text.push_back(8'(8'h31 + $urandom_range(8)));
                    repeat (nd - 1) text.push_back(8'(8'h30 + $urandom_range(9)));
                end
                RX_HEX: begin
                    text.push_back(CH_ZERO);
                    text.push_back(CH_X);
                    nd = long_run ? $urandom_range(14, 20) : $urandom_range(0, 5);
                    repeat (nd) begin
                        d     = $urandom_range(15);
                        upper = $urandom_range(1);
                        if (d < 10) begin
                            text.push_back(8'(8'h30 + d));
                        end else begin
                            text.push_back(8'((upper ? 8'h41 : 8'h61) + d - 10));
                        end
                    end
                end
                RX_OCT: begin
                    text.push_back(CH_ZERO);
                    nd = long_run ? $urandom_range(20, 26) : $urandom_range(0, 6);
                    repeat (nd) text.push_back(8'(8'h30 + $urandom_range(7)));
                end
                default: begin
                    text.push_back(CH_ZERO);
                    text.push_back(CH_B);
                    nd = long_run ? $urandom_range(60, 68) : $urandom_range(0, 8);
                    repeat (nd) text.push_back(8'(8'h30 + $urandom_range(1)));
                end
            endcase
            if ($urandom_range(99) < 15) begin
                pos = $urandom_range(text.size() - 1);
                if ($urandom_range(1)) begin
                    text[pos] = 8'($urandom_range(255));
                end else begin
                    text.insert(pos, 8'($urandom_range(255)));
                end
            end
        end
        foreach (text[i]) begin
            queue_char(text[i], i == text.size() - 1);
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= m_idle_pct);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
                s_data  <= pending_chars.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        out_beat_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL numeric_literal_parser");
            $finish;
        end
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            parse_char(s_data);
        end
        if (aresetn && m_valid && m_ready) begin
            if (parsed_values.size() == 0) begin
                report_mismatch("unexpected result value", m_data.value, '0);
            end else begin
                want = parsed_values.pop_front();
                if (m_data.value !== want.value) begin
                    report_mismatch("value", m_data.value, want.value);
                end
                if (m_data.bad_char !== want.bad_char) begin
                    report_mismatch("bad_char", 64'(m_data.bad_char), 64'(want.bad_char));
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 3; p++) begin
            if (p == 0) begin
                s_idle_pct = 6;
                m_idle_pct = 80;
            end else if (p == 1) begin
                s_idle_pct = 80;
                m_idle_pct = 6;
            end else begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            phase_items = 0;
            if (p == 0) begin
                queue_text("-");
                queue_text("0x");
                queue_text("-0x");
                queue_text("0b");
                queue_text("--5");
                queue_text("0X1");
                queue_char(8'h00, 1'b1);
                queue_text("0xaF");
                queue_text("-9");
                queue_text("0b2");
                queue_char(8'hff, 1'b1);
            end
            while (phase_items < PHASE_ITEMS) begin
                gen_literal();
            end
            while (pending_chars.size() != 0 || s_valid || parsed_values.size() != 0) begin
                @(negedge aclk);
            end
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS numeric_literal_parser");
        end else begin
            $display("FAIL numeric_literal_parser");
        end
        $finish;
    end

endmodule

### files.f
hdl/nlp_pkg.sv
hdl/nlp_digit_unit.sv
hdl/numeric_literal_parser.sv
hdl/nlp_checker.sv
test/numeric_literal_parser_tb.sv
